// ===== rtl/core/cubic_bisection_root_macros.svh =====
// Assertion helpers for the block's top-level RTL file.
`ifndef CUBIC_BISECTION_ROOT_MACROS_SVH
`define CUBIC_BISECTION_ROOT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while in reset.
`define CBR_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while in reset.
`define CBR_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cbr_pkg.sv =====
package cbr_pkg;

    localparam int MAX_STEPS_DEF = 48;
    localparam int FRAC_BITS     = 16;

    localparam int COEF_W    = 32;
    localparam int WIDE_W    = 63;
    localparam int MAG_W     = 62;
    localparam int TOL_W     = 31;
    localparam int STEPS_W   = 6;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int UPC_W     = 6;

    localparam logic [TOL_W-1:0] TOL_RESET = 31'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CUBIC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_CONV  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd2;

    typedef logic [UPC_W-1:0] t_upc;

    // sequencer jump codes
    localparam logic [2:0] J_NEXT    = 3'd0;
    localparam logic [2:0] J_WAIT    = 3'd1;
    localparam logic [2:0] J_GOTO    = 3'd2;
    localparam logic [2:0] J_CALL    = 3'd3;
    localparam logic [2:0] J_RET     = 3'd4;
    localparam logic [2:0] J_IF_BAD  = 3'd5;
    localparam logic [2:0] J_IF_CONV = 3'd6;
    localparam logic [2:0] J_IF_MORE = 3'd7;

    // multiplier engine operations
    localparam logic [2:0] M_NONE = 3'd0;
    localparam logic [2:0] M_LD   = 3'd1;
    localparam logic [2:0] M_ML   = 3'd2;
    localparam logic [2:0] M_MH   = 3'd3;
    localparam logic [2:0] M_SUM  = 3'd4;
    localparam logic [2:0] M_FIN  = 3'd5;

    // wide operand select
    localparam logic [1:0] A_N  = 2'd0;
    localparam logic [1:0] A_N2 = 2'd1;
    localparam logic [1:0] A_N3 = 2'd2;

    // narrow operand select
    localparam logic [1:0] B_N  = 2'd0;
    localparam logic [1:0] B_C3 = 2'd1;
    localparam logic [1:0] B_C2 = 2'd2;
    localparam logic [1:0] B_C1 = 2'd3;

    // save product to power register
    localparam logic [1:0] SV_NONE = 2'd0;
    localparam logic [1:0] SV_N2   = 2'd1;
    localparam logic [1:0] SV_N3   = 2'd2;

    // accumulator operations
    localparam logic [1:0] T_NONE = 2'd0;
    localparam logic [1:0] T_LOAD = 2'd1;
    localparam logic [1:0] T_ADD  = 2'd2;
    localparam logic [1:0] T_ADDC = 2'd3;

    // evaluation point operations
    localparam logic [1:0] N_NONE = 2'd0;
    localparam logic [1:0] N_A    = 2'd1;
    localparam logic [1:0] N_B    = 2'd2;
    localparam logic [1:0] N_MID  = 2'd3;

    // program labels
    localparam t_upc UA_IDLE  = 6'd0;
    localparam t_upc UA_LOOP  = 6'd4;
    localparam t_upc UA_LIMIT = 6'd7;
    localparam t_upc UA_CONV  = 6'd8;
    localparam t_upc UA_BAD   = 6'd9;
    localparam t_upc UA_EVAL  = 6'd10;

    typedef struct packed {
        logic [2:0]          jump;
        t_upc                target;
        logic [2:0]          mop;
        logic [1:0]          asel;
        logic [1:0]          bsel;
        logic [1:0]          save;
        logic [1:0]          top;
        logic [1:0]          nop;
        logic                clr_cnt;
        logic                save_fa;
        logic                upd;
        logic                emit;
        logic [STATUS_W-1:0] status;
    } t_uword;

    typedef struct packed {
        t_uword uw;
        logic   accept;
    } t_ctl;

    typedef struct packed {
        logic same;
        logic conv;
        logic more;
    } t_flags;

    // Control store. The cubic evaluation is a subroutine at UA_EVAL:
    // five products, each fetch / low half / high half / sum / finish.
    function automatic t_uword ucode(input t_upc addr);
        t_uword w;
        w = '0;
        unique case (addr)
            UA_IDLE: w.jump = J_WAIT;
            6'd1: begin
                w.nop     = N_A;
                w.clr_cnt = 1'b1;
                w.jump    = J_CALL;
                w.target  = UA_EVAL;
            end
            6'd2: begin
                w.save_fa = 1'b1;
                w.nop     = N_B;
                w.jump    = J_CALL;
                w.target  = UA_EVAL;
            end
            6'd3: begin
                w.jump   = J_IF_BAD;
                w.target = UA_BAD;
            end
            UA_LOOP: begin
                w.nop    = N_MID;
                w.jump   = J_CALL;
                w.target = UA_EVAL;
            end
            6'd5: begin
                w.jump   = J_IF_CONV;
                w.target = UA_CONV;
            end
            6'd6: begin
                w.upd    = 1'b1;
                w.jump   = J_IF_MORE;
                w.target = UA_LOOP;
            end
            UA_LIMIT: begin
                w.emit   = 1'b1;
                w.status = ST_LIMIT;
                w.jump   = J_GOTO;
                w.target = UA_IDLE;
            end
            UA_CONV: begin
                w.emit   = 1'b1;
                w.status = ST_CONV;
                w.jump   = J_GOTO;
                w.target = UA_IDLE;
            end
            UA_BAD: begin
                w.emit   = 1'b1;
                w.status = ST_BAD;
                w.jump   = J_GOTO;
                w.target = UA_IDLE;
            end
            UA_EVAL: begin
                w.mop  = M_LD;
                w.asel = A_N;
                w.bsel = B_N;
            end
            6'd11, 6'd16, 6'd21, 6'd26, 6'd31: w.mop = M_ML;
            6'd12, 6'd17, 6'd22, 6'd27, 6'd32: w.mop = M_MH;
            6'd13, 6'd18, 6'd23, 6'd28, 6'd33: w.mop = M_SUM;
            6'd14: begin
                w.mop  = M_FIN;
                w.save = SV_N2;
            end
            6'd15: begin
                w.mop  = M_LD;
                w.asel = A_N2;
                w.bsel = B_N;
            end
            6'd19: begin
                w.mop  = M_FIN;
                w.save = SV_N3;
            end
            6'd20: begin
                w.mop  = M_LD;
                w.asel = A_N3;
                w.bsel = B_C3;
            end
            6'd24, 6'd29, 6'd34: w.mop = M_FIN;
            6'd25: begin
                w.mop  = M_LD;
                w.asel = A_N2;
                w.bsel = B_C2;
                w.top  = T_LOAD;
            end
            6'd30: begin
                w.mop  = M_LD;
                w.asel = A_N;
                w.bsel = B_C1;
                w.top  = T_ADD;
            end
            6'd35: w.top = T_ADD;
            6'd36: begin
                w.top  = T_ADDC;
                w.jump = J_RET;
            end
            default: begin
                w.jump   = J_GOTO;
                w.target = UA_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/cubic_bisection_root.sv =====
// Cubic root finder by bisection, signed Q16.16 in and out.
// Configuration: write coefficients (index 0 cubic .. 3 constant) and the
// tolerance (index 4) on the cfg channel while the block is idle; the
// channel is always ready. Reset sets coefficients to 0, tolerance to 7.
// Command: raise start with lower_end/upper_end; the beat is taken when
// busy is low. busy stays high until the result comes out.
// Result: o_done pulses for one cycle with root, steps and status; the
// receiver cannot stall, so sample it then. busy is already low in that
// cycle, so the next command can go in at the same edge.
// Each cubic evaluation runs five products through the single 32x32
// multiplier, five control steps each, plus two steps for the last two of
// the three saturating adds (the first one overlaps a product fetch).
// The control store steps one word per cycle; f(a) is kept by sign, so
// each halving costs one evaluation. Reset returns to idle at once.
module cubic_bisection_root #(
    parameter int MAX_STEPS = cbr_pkg::MAX_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cbr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cbr_pkg::COEF_W-1:0]         i_cfg_data,
    input  logic signed [cbr_pkg::COEF_W-1:0]  i_lower_end,
    input  logic signed [cbr_pkg::COEF_W-1:0]  i_upper_end,
    output logic                               o_done,
    output logic signed [cbr_pkg::COEF_W-1:0]  o_root,
    output logic [cbr_pkg::STEPS_W-1:0]        o_steps,
    output logic [cbr_pkg::STATUS_W-1:0]       o_status
);

    `include "cubic_bisection_root_macros.svh"

    localparam int STEPS_W = cbr_pkg::STEPS_W;

    cbr_pkg::t_ctl   w_ctl;
    cbr_pkg::t_flags w_flags;

    assign o_cfg_ready = 1'b1;

    cbr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (w_flags),
        .o_ctl   (w_ctl),
        .o_busy  (busy)
    );

    cbr_dp #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_lower_end (i_lower_end),
        .i_upper_end (i_upper_end),
        .i_ctl       (w_ctl),
        .o_flags     (w_flags),
        .o_done      (o_done),
        .o_root      (o_root),
        .o_steps     (o_steps),
        .o_status    (o_status)
    );

    `CBR_ASSERT_IMP(a_done_idle, o_done, !busy, "result beat while busy")
    `CBR_ASSERT_NXT(a_start_busy, start && !busy, busy, "command beat did not start work")
    `CBR_ASSERT_NXT(a_done_once, o_done, !o_done, "result beat repeated")
    `CBR_ASSERT_IMP(a_bad_zero, o_done && o_status == cbr_pkg::ST_BAD, o_root == '0 && o_steps == '0, "bad interval with nonzero fields")
    `CBR_ASSERT_IMP(a_limit_steps, o_done && o_status == cbr_pkg::ST_LIMIT, o_steps == STEPS_W'(MAX_STEPS), "step limit with wrong count")

endmodule

// ===== rtl/core/cbr_seq.sv =====
module cbr_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  cbr_pkg::t_flags i_flags,
    output cbr_pkg::t_ctl   o_ctl,
    output logic            o_busy
);

    cbr_pkg::t_upc   r_pc;
    cbr_pkg::t_upc   n_pc;
    cbr_pkg::t_upc   r_ret;
    cbr_pkg::t_upc   n_ret;
    cbr_pkg::t_upc   w_inc;
    cbr_pkg::t_uword w_uw;
    logic            w_accept;

    assign w_uw     = cbr_pkg::ucode(r_pc);
    assign w_inc    = r_pc + 1'b1;
    assign o_busy   = (r_pc != cbr_pkg::UA_IDLE);
    assign w_accept = i_start && !o_busy;

    assign o_ctl.uw     = w_uw;
    assign o_ctl.accept = w_accept;

    always_comb begin
        n_pc  = w_inc;
        n_ret = r_ret;
        unique case (w_uw.jump)
            cbr_pkg::J_NEXT:    n_pc = w_inc;
            cbr_pkg::J_WAIT:    n_pc = w_accept ? w_inc : r_pc;
            cbr_pkg::J_GOTO:    n_pc = w_uw.target;
            cbr_pkg::J_CALL: begin
                n_pc  = w_uw.target;
                n_ret = w_inc;
            end
            cbr_pkg::J_RET:     n_pc = r_ret;
            cbr_pkg::J_IF_BAD:  n_pc = i_flags.same ? w_uw.target : w_inc;
            cbr_pkg::J_IF_CONV: n_pc = i_flags.conv ? w_uw.target : w_inc;
            cbr_pkg::J_IF_MORE: n_pc = i_flags.more ? w_uw.target : w_inc;
            default:            n_pc = cbr_pkg::UA_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= cbr_pkg::UA_IDLE;
            r_ret <= cbr_pkg::UA_IDLE;
        end else begin
            r_pc  <= n_pc;
            r_ret <= n_ret;
        end
    end

endmodule

// ===== rtl/core/cbr_dp.sv =====
module cbr_dp #(
    parameter int MAX_STEPS = cbr_pkg::MAX_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [cbr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cbr_pkg::COEF_W-1:0]        i_cfg_data,
    input  logic signed [cbr_pkg::COEF_W-1:0] i_lower_end,
    input  logic signed [cbr_pkg::COEF_W-1:0] i_upper_end,
    input  cbr_pkg::t_ctl                     i_ctl,
    output cbr_pkg::t_flags                   o_flags,
    output logic                              o_done,
    output logic signed [cbr_pkg::COEF_W-1:0] o_root,
    output logic [cbr_pkg::STEPS_W-1:0]       o_steps,
    output logic [cbr_pkg::STATUS_W-1:0]      o_status
);

    localparam int CNT_W   = $clog2(MAX_STEPS + 1);
    localparam int COEF_W  = cbr_pkg::COEF_W;
    localparam int WIDE_W  = cbr_pkg::WIDE_W;
    localparam int MAG_W   = cbr_pkg::MAG_W;
    localparam int STEPS_W = cbr_pkg::STEPS_W;
    localparam int ACC_W   = MAG_W + COEF_W;
    localparam int HI_W    = MAG_W - COEF_W;
    localparam logic signed [WIDE_W:0] SUM_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [WIDE_W:0] SUM_MIN = -64'sh3FFF_FFFF_FFFF_FFFF;

    cbr_pkg::t_uword w_uw;

    logic [COEF_W-1:0]   r_c3;
    logic [COEF_W-1:0]   r_c2;
    logic [COEF_W-1:0]   r_c1;
    logic [COEF_W-1:0]   r_c0;
    logic [cbr_pkg::TOL_W-1:0] r_tol;

    logic [COEF_W-1:0]   r_a;
    logic [COEF_W-1:0]   r_b;
    logic [COEF_W-1:0]   r_c;
    logic [COEF_W-1:0]   r_n;
    logic [WIDE_W-1:0]   r_n2;
    logic [WIDE_W-1:0]   r_n3;
    logic [MAG_W-1:0]    r_mag_a;
    logic [COEF_W-1:0]   r_mag_b;
    logic                r_neg;
    logic [2*COEF_W-1:0] r_plo;
    logic [MAG_W-1:0]    r_phi;
    logic [ACC_W-1:0]    r_acc;
    logic [WIDE_W-1:0]   r_prod;
    logic [WIDE_W-1:0]   r_t;
    logic                r_fa_neg;
    logic                r_fa_zero;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_done;
    logic [COEF_W-1:0]   r_root;
    logic [STEPS_W-1:0]  r_steps;
    logic [cbr_pkg::STATUS_W-1:0] r_status;

    logic [WIDE_W-1:0]   w_opa;
    logic [WIDE_W-1:0]   w_opa_abs;
    logic [COEF_W-1:0]   w_opb;
    logic [COEF_W:0]     w_opb_ext;
    logic [COEF_W:0]     w_opb_abs;
    logic [COEF_W-1:0]   w_mul_x;
    logic [2*COEF_W-1:0] w_mul;
    logic [ACC_W-1:0]    w_sh;
    logic                w_sat;
    logic [MAG_W-1:0]    w_mag;
    logic [WIDE_W-1:0]   w_fin;
    logic [WIDE_W-1:0]   w_addend;
    logic [WIDE_W-1:0]   w_tsum;
    logic [COEF_W:0]     w_sum_ab;
    logic [COEF_W-1:0]   w_mid;
    logic                w_t_neg;
    logic                w_t_zero;
    logic [WIDE_W-1:0]   w_tabs;
    logic                w_bad_emit;

    function automatic logic [WIDE_W-1:0] sat_add(input logic [WIDE_W-1:0] x,
                                                  input logic [WIDE_W-1:0] y);
        logic signed [WIDE_W:0] s;
        s = $signed({x[WIDE_W-1], x}) + $signed({y[WIDE_W-1], y});
        if (s > SUM_MAX) begin
            return SUM_MAX[WIDE_W-1:0];
        end else if (s < SUM_MIN) begin
            return SUM_MIN[WIDE_W-1:0];
        end
        return s[WIDE_W-1:0];
    endfunction

    assign w_uw = i_ctl.uw;

    // operand fetch: sign-magnitude split for the product
    always_comb begin
        unique case (w_uw.asel)
            cbr_pkg::A_N2: w_opa = r_n2;
            cbr_pkg::A_N3: w_opa = r_n3;
            default:       w_opa = {{(WIDE_W-COEF_W){r_n[COEF_W-1]}}, r_n};
        endcase
    end

    always_comb begin
        unique case (w_uw.bsel)
            cbr_pkg::B_N:  w_opb = r_n;
            cbr_pkg::B_C3: w_opb = r_c3;
            cbr_pkg::B_C2: w_opb = r_c2;
            cbr_pkg::B_C1: w_opb = r_c1;
            default:       w_opb = r_n;
        endcase
    end

    assign w_opa_abs = w_opa[WIDE_W-1] ? -w_opa : w_opa;
    assign w_opb_ext = {w_opb[COEF_W-1], w_opb};
    assign w_opb_abs = w_opb[COEF_W-1] ? -w_opb_ext : w_opb_ext;

    // one shared 32x32 multiplier: low half of the wide magnitude, then high half
    assign w_mul_x = (w_uw.mop == cbr_pkg::M_MH) ? {{(COEF_W-HI_W){1'b0}}, r_mag_a[MAG_W-1:COEF_W]}
                                                 : r_mag_a[COEF_W-1:0];
    assign w_mul   = w_mul_x * r_mag_b;

    // drop fraction bits, clamp to the wide range, restore sign
    assign w_sh  = r_acc >> cbr_pkg::FRAC_BITS;
    assign w_sat = |w_sh[ACC_W-1:MAG_W];
    assign w_mag = w_sat ? {MAG_W{1'b1}} : w_sh[MAG_W-1:0];
    assign w_fin = r_neg ? -{1'b0, w_mag} : {1'b0, w_mag};

    assign w_addend = (w_uw.top == cbr_pkg::T_ADDC) ? {{(WIDE_W-COEF_W){r_c0[COEF_W-1]}}, r_c0}
                                                    : r_prod;
    assign w_tsum   = sat_add(r_t, w_addend);

    // floor of the half sum
    assign w_sum_ab = {r_a[COEF_W-1], r_a} + {r_b[COEF_W-1], r_b};
    assign w_mid    = w_sum_ab[COEF_W:1];

    assign w_t_neg  = r_t[WIDE_W-1];
    assign w_t_zero = (r_t == '0);
    assign w_tabs   = w_t_neg ? -r_t : r_t;

    assign o_flags.same = !w_t_zero && !r_fa_zero && (w_t_neg == r_fa_neg);
    assign o_flags.conv = (w_tabs[MAG_W-1:0] <= MAG_W'(r_tol));
    assign o_flags.more = (r_cnt != CNT_W'(MAX_STEPS));

    assign w_bad_emit = (w_uw.status == cbr_pkg::ST_BAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c3  <= '0;
            r_c2  <= '0;
            r_c1  <= '0;
            r_c0  <= '0;
            r_tol <= cbr_pkg::TOL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cbr_pkg::CFG_CUBIC:  r_c3  <= i_cfg_data;
                cbr_pkg::CFG_SQUARE: r_c2  <= i_cfg_data;
                cbr_pkg::CFG_LINEAR: r_c1  <= i_cfg_data;
                cbr_pkg::CFG_CONST:  r_c0  <= i_cfg_data;
                cbr_pkg::CFG_TOL:    r_tol <= i_cfg_data[cbr_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= w_uw.emit;
            if (w_uw.clr_cnt) begin
                r_cnt <= '0;
            end else if (w_uw.nop == cbr_pkg::N_MID) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_a <= i_lower_end;
            r_b <= i_upper_end;
        end else if (w_uw.upd) begin
            // keep the half whose ends differ in sign
            if (o_flags.same) begin
                r_a <= r_c;
            end else begin
                r_b <= r_c;
            end
        end

        unique case (w_uw.nop)
            cbr_pkg::N_A: r_n <= r_a;
            cbr_pkg::N_B: r_n <= r_b;
            cbr_pkg::N_MID: begin
                r_n <= w_mid;
                r_c <= w_mid;
            end
            default: ;
        endcase

        if (w_uw.save_fa) begin
            r_fa_neg  <= w_t_neg;
            r_fa_zero <= w_t_zero;
        end

        unique case (w_uw.mop)
            cbr_pkg::M_LD: begin
                r_mag_a <= w_opa_abs[MAG_W-1:0];
                r_mag_b <= w_opb_abs[COEF_W-1:0];
                r_neg   <= w_opa[WIDE_W-1] ^ w_opb[COEF_W-1];
            end
            cbr_pkg::M_ML:  r_plo <= w_mul;
            cbr_pkg::M_MH:  r_phi <= w_mul[MAG_W-1:0];
            cbr_pkg::M_SUM: r_acc <= {{(ACC_W-2*COEF_W){1'b0}}, r_plo} + {r_phi, {COEF_W{1'b0}}};
            cbr_pkg::M_FIN: begin
                r_prod <= w_fin;
                if (w_uw.save == cbr_pkg::SV_N2) begin
                    r_n2 <= w_fin;
                end
                if (w_uw.save == cbr_pkg::SV_N3) begin
                    r_n3 <= w_fin;
                end
            end
            default: ;
        endcase

        unique case (w_uw.top)
            cbr_pkg::T_LOAD: r_t <= r_prod;
            cbr_pkg::T_ADD,
            cbr_pkg::T_ADDC: r_t <= w_tsum;
            default: ;
        endcase

        if (w_uw.emit) begin
            r_status <= w_uw.status;
            r_root   <= w_bad_emit ? '0 : r_c;
            r_steps  <= w_bad_emit ? '0 : STEPS_W'(r_cnt);
        end
    end

    assign o_done   = r_done;
    assign o_root   = r_root;
    assign o_steps  = r_steps;
    assign o_status = r_status;

endmodule
